/* hw/rtl/pgd_pkg.sv */
// Shared types and constants of the pinch gesture detector.
package pgd_pkg;

    localparam int COORD_W   = 16;
    localparam int DIST_W    = 17;
    localparam int TIME_W    = 32;
    localparam int WCNT_W    = 3;
    localparam int RAD_W     = 33;
    localparam int DIV_N     = 27;
    localparam int DIV_M     = 36;
    localparam int SPEED_W   = 20;
    localparam int SPEED_MUL = 1000;

    localparam logic [15:0]      SCALE_MAX = 16'hFFFF;
    localparam logic [SPEED_W-1:0] SPEED_MAX = 20'hFFFFF;

    typedef enum logic [2:0] {
        MODE_CLEAR    = 3'b001,
        MODE_POSSIBLE = 3'b010,
        MODE_STARTED  = 3'b100
    } t_mode;

    typedef enum logic [1:0] {
        KIND_STARTED    = 2'd0,
        KIND_CONTINUING = 2'd1,
        KIND_FINISHED   = 2'd2,
        KIND_CANCELLED  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [3:0]         point_count;
        logic [COORD_W-1:0] first_x;
        logic [COORD_W-1:0] first_y;
        logic [COORD_W-1:0] second_x;
        logic [COORD_W-1:0] second_y;
        logic               first_lifted;
        logic               second_lifted;
        logic [TIME_W-1:0]  stamp_ms;
    } t_in;

    typedef struct packed {
        logic [1:0]         gesture_kind;
        logic [15:0]        scale_q8;
        logic [SPEED_W-1:0] speed_px_s;
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic [TIME_W-1:0]  out_time_ms;
        logic               saturated;
    } t_out;

    typedef struct packed {
        logic  latch;
        logic  square;
        logic  root_start;
        logic  push;
        logic  push_reset;
        logic  win_clear;
        logic  set_sd;
        logic  div_start;
        logic  cancel;
        t_kind kind;
    } t_cmd;

    typedef struct packed {
        logic              is_two;
        logic              lifted;
        logic [WCNT_W-1:0] wcount;
        logic              dd_gt_min;
        logic              root_done;
        logic              div_done;
    } t_stat;

endpackage

/* hw/rtl/pinch_gesture_detector.sv */
// Top level of the pinch gesture detector: ports, register file, result buffer.
// A report that gives no result passes through square, bit-serial root and update.
// A result also runs the two 27-step dividers side by side.
// A new report is taken only in idle, once the last one is through.
// A cancelled result skips the dividers.
// Reset (synchronous, active low) returns to clear mode, empties the window, zeroes the threshold.
module pinch_gesture_detector
    import pgd_pkg::*;
#(
    parameter int WINDOW_EVENTS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // report channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    // gesture channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cmd        cmd;
    t_stat       stat;
    t_out        result;
    logic        out_load;
    logic        out_free;

    logic [15:0] r_min_dist;
    logic        r_out_valid;
    t_out        r_out;

    // Threshold register: the only register, at byte addresses 0 to 3 (paddr[2] low).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dist <= '0;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_min_dist <= pwdata[15:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'h0 : {16'h0, r_min_dist};

    // Result buffer: hold a gesture until its transfer, so the next report can start.
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (out_load) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    pgd_ctrl #(
        .WINDOW_EVENTS (WINDOW_EVENTS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_out_load (out_load),
        .o_cmd      (cmd)
    );

    pgd_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_item     (i_in_data),
        .i_min_dist (r_min_dist),
        .o_stat     (stat),
        .o_result   (result)
    );

endmodule

/* hw/rtl/pgd_isqrt.sv */
// Bit-serial integer square root, one root bit per cycle.
module pgd_isqrt
    import pgd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [RAD_W-1:0] i_radicand,
    output logic             o_done,
    output logic [DIST_W-1:0] o_root
);

    logic [2*DIST_W-1:0] r_rad, n_rad;
    logic [DIST_W+2:0]   r_rem, n_rem;
    logic [DIST_W-1:0]   r_root, n_root;
    logic [4:0]          r_cnt, n_cnt;
    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [DIST_W+2:0]   rem_sh;
    logic [DIST_W+2:0]   trial;

    always_comb begin
        rem_sh = {r_rem[DIST_W:0], r_rad[2*DIST_W-1 -: 2]};
        trial  = {1'b0, r_root, 2'b01};
        n_rad  = r_rad;
        n_rem  = r_rem;
        n_root = r_root;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rad  = {1'b0, i_radicand};
            n_rem  = '0;
            n_root = '0;
            n_cnt  = 5'(DIST_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rad = {r_rad[2*DIST_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                n_rem  = rem_sh - trial;
                n_root = {r_root[DIST_W-2:0], 1'b1};
            end else begin
                n_rem  = rem_sh;
                n_root = {r_root[DIST_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

/* hw/rtl/pgd_div.sv */
// Restoring divider, one quotient bit per cycle.
module pgd_div
    import pgd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_N-1:0] i_dividend,
    input  logic [DIV_M-1:0] i_divisor,
    output logic             o_done,
    output logic [DIV_N-1:0] o_quot
);

    logic [DIV_N-1:0] r_q, n_q;
    logic [DIV_M-1:0] r_rem, n_rem;
    logic [DIV_M-1:0] r_div, n_div;
    logic [4:0]       r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [DIV_M:0]   rem_sh;

    always_comb begin
        rem_sh = {r_rem, r_q[DIV_N-1]};
        n_q    = r_q;
        n_rem  = r_rem;
        n_div  = r_div;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_q    = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
            n_cnt  = 5'(DIV_N);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (rem_sh >= {1'b0, r_div}) begin
                n_rem = DIV_M'(rem_sh - {1'b0, r_div});
                n_q   = {r_q[DIV_N-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[DIV_M-1:0];
                n_q   = {r_q[DIV_N-2:0], 1'b0};
            end
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

/* hw/rtl/pgd_datapath.sv */
// Window state, distance, scale and speed datapath.
module pgd_datapath
    import pgd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  t_in         i_item,
    input  logic [15:0] i_min_dist,
    output t_stat       o_stat,
    output t_out        o_result
);

    t_in                r_item;
    logic [COORD_W-1:0] r_dx, r_dy;
    logic [2*COORD_W-1:0] r_sqx, r_sqy;
    logic [DIST_W-1:0]  r_dist;
    logic [WCNT_W-1:0]  r_wcount;
    logic [DIST_W-1:0]  r_wfd;
    logic [TIME_W-1:0]  r_wft;
    logic [DIST_W-1:0]  r_sd;
    logic [COORD_W-1:0] r_lp [4];

    logic [COORD_W-1:0] sel_ax, sel_ay, sel_bx, sel_by;
    logic [DIST_W-1:0]  root;
    logic               root_done;
    logic [DIST_W-1:0]  dd;
    logic [TIME_W-1:0]  dt;
    logic [DIV_N-1:0]   speed_num;
    logic [DIV_N-1:0]   scale_quot, speed_quot;
    logic               scale_done, speed_done;
    logic [COORD_W:0]   sum_x, sum_y;

    // Distance is taken from the new points, or from the held ones when
    // the report has no pair.
    always_comb begin
        if (i_item.point_count == 4'd2) begin
            sel_ax = i_item.first_x;
            sel_ay = i_item.first_y;
            sel_bx = i_item.second_x;
            sel_by = i_item.second_y;
        end else begin
            sel_ax = r_lp[0];
            sel_ay = r_lp[1];
            sel_bx = r_lp[2];
            sel_by = r_lp[3];
        end
    end

    assign dd        = (r_wfd > r_dist) ? r_wfd - r_dist : r_dist - r_wfd;
    assign dt        = r_item.stamp_ms - r_wft;
    assign speed_num = DIV_N'(dd) * DIV_N'(SPEED_MUL);

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_item;
            r_dx   <= (sel_ax > sel_bx) ? sel_ax - sel_bx : sel_bx - sel_ax;
            r_dy   <= (sel_ay > sel_by) ? sel_ay - sel_by : sel_by - sel_ay;
        end
        if (i_cmd.square) begin
            r_sqx <= r_dx * r_dx;
            r_sqy <= r_dy * r_dy;
        end
        if (root_done) begin
            r_dist <= root;
        end
        if (i_cmd.push) begin
            r_lp[0] <= r_item.first_x;
            r_lp[1] <= r_item.first_y;
            r_lp[2] <= r_item.second_x;
            r_lp[3] <= r_item.second_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wcount <= '0;
            r_wfd    <= '0;
            r_wft    <= '0;
            r_sd     <= '0;
        end else begin
            if (i_cmd.push && i_cmd.push_reset) begin
                r_wfd <= r_dist;
                r_wft <= r_item.stamp_ms;
            end
            if (i_cmd.set_sd) begin
                r_sd <= i_cmd.push_reset ? r_dist : r_wfd;
            end
            if (i_cmd.win_clear) begin
                r_wcount <= '0;
            end else if (i_cmd.push) begin
                r_wcount <= i_cmd.push_reset ? WCNT_W'(1) : r_wcount + WCNT_W'(1);
            end
        end
    end

    pgd_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.root_start),
        .i_radicand ({1'b0, r_sqx} + {1'b0, r_sqy}),
        .o_done     (root_done),
        .o_root     (root)
    );

    pgd_div u_div_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (DIV_N'({r_dist, 8'h00})),
        .i_divisor  (DIV_M'(r_sd)),
        .o_done     (scale_done),
        .o_quot     (scale_quot)
    );

    pgd_div u_div_speed (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (speed_num),
        .i_divisor  ({dt, 4'h0}),
        .o_done     (speed_done),
        .o_quot     (speed_quot)
    );

    assign sum_x = {1'b0, r_lp[0]} + {1'b0, r_lp[2]};
    assign sum_y = {1'b0, r_lp[1]} + {1'b0, r_lp[3]};

    always_comb begin
        o_result             = '0;
        o_result.out_time_ms = r_item.stamp_ms;
        if (i_cmd.cancel) begin
            o_result.gesture_kind = KIND_CANCELLED;
        end else begin
            o_result.gesture_kind = i_cmd.kind;
            o_result.center_x     = sum_x[COORD_W:1];
            o_result.center_y     = sum_y[COORD_W:1];
            if (r_sd == '0) begin
                o_result.scale_q8  = SCALE_MAX;
                o_result.saturated = 1'b1;
            end else if (scale_quot > DIV_N'(SCALE_MAX)) begin
                o_result.scale_q8 = SCALE_MAX;
            end else begin
                o_result.scale_q8 = scale_quot[15:0];
            end
            if (dt == '0) begin
                o_result.speed_px_s = SPEED_MAX;
                o_result.saturated  = 1'b1;
            end else if (speed_quot > DIV_N'(SPEED_MAX)) begin
                o_result.speed_px_s = SPEED_MAX;
            end else begin
                o_result.speed_px_s = speed_quot[SPEED_W-1:0];
            end
        end
    end

    always_comb begin
        o_stat           = '0;
        o_stat.is_two    = (r_item.point_count == 4'd2);
        o_stat.lifted    = r_item.first_lifted | r_item.second_lifted;
        o_stat.wcount    = r_wcount;
        o_stat.dd_gt_min = (dd > DIST_W'(i_min_dist));
        o_stat.root_done = root_done;
        o_stat.div_done  = scale_done & speed_done;
    end

endmodule

/* hw/rtl/pgd_ctrl.sv */
// Sequencer and gesture mode controller.
module pgd_ctrl
    import pgd_pkg::*;
#(
    parameter int WINDOW_EVENTS = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_out_free,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output logic  o_out_load,
    output t_cmd  o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_SQUARE    = 8'b0000_0010,
        S_ROOT_GO   = 8'b0000_0100,
        S_ROOT_WAIT = 8'b0000_1000,
        S_EVAL      = 8'b0001_0000,
        S_DIV_GO    = 8'b0010_0000,
        S_DIV_WAIT  = 8'b0100_0000,
        S_OUT       = 8'b1000_0000
    } t_state;

    localparam logic [3:0] WIN = 4'(WINDOW_EVENTS);

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;
    t_kind  r_kind, n_kind;
    logic   r_cancel, n_cancel;

    logic [3:0] wc;
    logic       reset_w;
    logic [3:0] wc_after;
    logic       full;
    logic       emit;

    assign wc       = {1'b0, i_stat.wcount};
    assign reset_w  = (wc == 4'd0) || (wc >= WIN);
    assign wc_after = reset_w ? 4'd1 : wc + 4'd1;
    assign full     = (wc + 4'd1) >= WIN;

    always_comb begin
        n_state         = r_state;
        n_mode          = r_mode;
        n_kind          = r_kind;
        n_cancel        = r_cancel;
        emit            = 1'b0;
        o_cmd           = '0;
        o_cmd.kind      = r_kind;
        o_cmd.cancel    = r_cancel;
        o_cmd.push_reset = reset_w;
        o_in_ready      = (r_state == S_IDLE);
        o_out_load      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_SQUARE;
                end
            end
            S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = S_ROOT_GO;
            end
            S_ROOT_GO: begin
                o_cmd.root_start = 1'b1;
                n_state          = S_ROOT_WAIT;
            end
            S_ROOT_WAIT: begin
                if (i_stat.root_done) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_cancel = 1'b0;
                case (r_mode)
                    MODE_CLEAR: begin
                        if (i_stat.is_two) begin
                            o_cmd.push = 1'b1;
                            n_mode     = MODE_POSSIBLE;
                        end
                    end
                    MODE_POSSIBLE: begin
                        if (!i_stat.is_two || i_stat.lifted) begin
                            o_cmd.win_clear = 1'b1;
                            n_mode          = MODE_CLEAR;
                        end else begin
                            o_cmd.push = 1'b1;
                            if (full) begin
                                o_cmd.win_clear = 1'b1;
                                if (i_stat.dd_gt_min) begin
                                    o_cmd.set_sd = 1'b1;
                                    emit         = 1'b1;
                                    n_kind       = KIND_STARTED;
                                    n_mode       = MODE_STARTED;
                                end else begin
                                    n_mode = MODE_CLEAR;
                                end
                            end
                        end
                    end
                    MODE_STARTED: begin
                        if (!i_stat.is_two) begin
                            // Finish from the held window; an empty one cancels.
                            emit            = 1'b1;
                            n_kind          = KIND_FINISHED;
                            n_cancel        = (wc == 4'd0);
                            o_cmd.win_clear = 1'b1;
                            n_mode          = MODE_CLEAR;
                        end else if (i_stat.lifted) begin
                            o_cmd.push      = 1'b1;
                            emit            = 1'b1;
                            n_kind          = KIND_FINISHED;
                            o_cmd.win_clear = 1'b1;
                            n_mode          = MODE_CLEAR;
                        end else begin
                            o_cmd.push = 1'b1;
                            if (wc_after >= WIN) begin
                                emit            = 1'b1;
                                n_kind          = KIND_CONTINUING;
                                o_cmd.win_clear = 1'b1;
                            end
                        end
                    end
                    default: begin
                        n_mode = MODE_CLEAR;
                    end
                endcase
                if (!emit) begin
                    n_state = S_IDLE;
                end else if (n_cancel) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_DIV_GO;
                end
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= MODE_CLEAR;
            r_kind   <= KIND_STARTED;
            r_cancel <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mode   <= n_mode;
            r_kind   <= n_kind;
            r_cancel <= n_cancel;
        end
    end

endmodule
